// ----- sv/rtpr_pkg.sv -----
// ----------------------------------------------------------------------------
// rtpr_pkg
// Shared widths, fixed-point constants and the arctangent table for the
// radial twist point rotation block.
// ----------------------------------------------------------------------------
package rtpr_pkg;

	// default coordinate width (signed Q16.16 at 32 bits)
	localparam int COORD_WIDTH_DEF = 32;

	// twist register, signed Q3.28 radians
	localparam int ANGLE_W = 31;

	// square root: radicand and root widths
	localparam int RAD_W  = 64;
	localparam int ROOT_W = 32;

	// CORDIC: angle word (Q.28) and sine/cosine words (Q.30)
	localparam int CORDIC_STEPS = 28;
	localparam int ANG_W        = 32;
	localparam int CS_W         = 34;

	// coordinates at or beyond this magnitude (Q16.16) take the far branch
	localparam int NEAR_LIMIT = 8388608;

	localparam longint PI_Q28      = 64'sd843314857;
	localparam longint HALF_PI_Q28 = 64'sd421657428;
	localparam longint TWO_PI_Q28  = 64'sd1686629713;
	localparam longint GAIN_Q30    = 64'sd652032874;

	// floor(2^32 / 7) and round(2^24 / 2pi) for the constant divisions
	localparam longint RECIP_7      = 64'd613566756;
	localparam longint RECIP_TWO_PI = 64'sd2670177;

	// arctan(2^-i) in Q.28
	function automatic logic [27:0] atan_q28(input int unsigned i);
		logic [27:0] v;
		unique case (i)
			0:  v = 28'd210828714;
			1:  v = 28'd124459457;
			2:  v = 28'd65760959;
			3:  v = 28'd33381289;
			4:  v = 28'd16755421;
			5:  v = 28'd8385879;
			6:  v = 28'd4193963;
			7:  v = 28'd2097109;
			8:  v = 28'd1048571;
			9:  v = 28'd524287;
			10: v = 28'd262144;
			11: v = 28'd131072;
			12: v = 28'd65536;
			13: v = 28'd32768;
			14: v = 28'd16384;
			15: v = 28'd8192;
			16: v = 28'd4096;
			17: v = 28'd2048;
			18: v = 28'd1024;
			19: v = 28'd512;
			20: v = 28'd256;
			21: v = 28'd128;
			22: v = 28'd64;
			23: v = 28'd32;
			24: v = 28'd16;
			25: v = 28'd8;
			26: v = 28'd4;
			27: v = 28'd2;
			default: v = 28'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- sv/rtpr_sqrt.sv -----
// ----------------------------------------------------------------------------
// rtpr_sqrt
// Pipelined integer square root: one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module rtpr_sqrt import rtpr_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [RAD_W-1:0]  radicand,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [ROOT_W-1:0] root,
	output logic [SIDE_W-1:0] side_out
);

	logic              vld_s  [0:ROOT_W];
	logic [RAD_W-1:0]  rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0] root_s [0:ROOT_W];
	logic [SIDE_W-1:0] side_s [0:ROOT_W];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = radicand;
	assign root_s[0] = '0;
	assign side_s[0] = side_in;

	// decide one root bit per stage, most significant first
	for (genvar j = 0; j < ROOT_W; j++) begin : g_bit
		localparam int K = ROOT_W - 1 - j;
		logic [RAD_W-1:0] trial;

		assign trial = (RAD_W'(root_s[j]) << (K + 1)) + (RAD_W'(1) << (2 * K));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_s[j] >= trial) begin
					rem_s[j+1]  <= rem_s[j] - trial;
					root_s[j+1] <= root_s[j] | (ROOT_W'(1) << K);
				end else begin
					rem_s[j+1]  <= rem_s[j];
					root_s[j+1] <= root_s[j];
				end
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign out_valid = vld_s[ROOT_W];
	assign root      = root_s[ROOT_W];
	assign side_out  = side_s[ROOT_W];

endmodule

// ----- sv/rtpr_cordic.sv -----
// ----------------------------------------------------------------------------
// rtpr_cordic
// Pipelined rotation-mode CORDIC: cosine and sine of a Q.28 angle in Q.30,
// one micro-rotation per stage, with a final half-turn flip stage.
// ----------------------------------------------------------------------------
module rtpr_cordic import rtpr_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic signed [ANG_W-1:0] angle,
	input  logic                   flip,
	input  logic [SIDE_W-1:0]      side_in,
	output logic                   out_valid,
	output logic signed [CS_W-1:0] cos_o,
	output logic signed [CS_W-1:0] sin_o,
	output logic [SIDE_W-1:0]      side_out
);

	logic                    vld_s  [0:CORDIC_STEPS];
	logic signed [CS_W-1:0]  cx_s   [0:CORDIC_STEPS];
	logic signed [CS_W-1:0]  cy_s   [0:CORDIC_STEPS];
	logic signed [ANG_W-1:0] az_s   [0:CORDIC_STEPS];
	logic                    flip_s [0:CORDIC_STEPS];
	logic [SIDE_W-1:0]       side_s [0:CORDIC_STEPS];

	logic                   vld_q;
	logic signed [CS_W-1:0] cos_q;
	logic signed [CS_W-1:0] sin_q;
	logic [SIDE_W-1:0]      side_q;

	assign vld_s[0]  = in_valid;
	assign cx_s[0]   = CS_W'(GAIN_Q30);
	assign cy_s[0]   = '0;
	assign az_s[0]   = angle;
	assign flip_s[0] = flip;
	assign side_s[0] = side_in;

	// rotate towards zero residual angle
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [CS_W-1:0]  cx_sh;
		logic signed [CS_W-1:0]  cy_sh;
		logic signed [ANG_W-1:0] at;

		assign cx_sh = cx_s[i] >>> i;
		assign cy_sh = cy_s[i] >>> i;
		assign at    = ANG_W'(atan_q28(i));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!az_s[i][ANG_W-1]) begin
					cx_s[i+1] <= cx_s[i] - cy_sh;
					cy_s[i+1] <= cy_s[i] + cx_sh;
					az_s[i+1] <= az_s[i] - at;
				end else begin
					cx_s[i+1] <= cx_s[i] + cy_sh;
					cy_s[i+1] <= cy_s[i] - cx_sh;
					az_s[i+1] <= az_s[i] + at;
				end
				flip_s[i+1] <= flip_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	// undo the half-turn fold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_s[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q  <= flip_s[CORDIC_STEPS] ? -cx_s[CORDIC_STEPS] : cx_s[CORDIC_STEPS];
			sin_q  <= flip_s[CORDIC_STEPS] ? -cy_s[CORDIC_STEPS] : cy_s[CORDIC_STEPS];
			side_q <= side_s[CORDIC_STEPS];
		end
	end

	assign out_valid = vld_q;
	assign cos_o     = cos_q;
	assign sin_o     = sin_q;
	assign side_out  = side_q;

endmodule

// ----- sv/radial_twist_point_rotation.sv -----
// ----------------------------------------------------------------------------
// radial_twist_point_rotation
// Twists a mesh point about the z axis by an angle that falls off smoothly
// with the radius; z passes through.
//
//   channel  dir  handshake               payload
//   s_axis   in   s_tvalid / s_tready     s_tdata: point_x, point_y, point_z
//   m_axis   out  m_tvalid / m_tready     m_tdata: moved_x, moved_y, moved_z
//   apb      in   psel, penable, pready   max_twist_angle at byte address 0
//
// One point per cycle while the output is not stalled; the pipeline
// includes the 32-stage square root and the 29-stage CORDIC.
// Reset clears all valid bits and the twist register; data needs no reset.
// A stalled output fills a one-word skid register; the pipeline then holds
// and s_tready drops until the skid word moves on.
// ----------------------------------------------------------------------------
module radial_twist_point_rotation import rtpr_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	localparam int TDW = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	// point_x, point_y, point_z, lowest bits first, zero padded
	input  logic [TDW-1:0] s_tdata,
	input  logic           s_tvalid,
	output logic           s_tready,
	// moved_x, moved_y, moved_z, lowest bits first, zero padded
	output logic [TDW-1:0] m_tdata,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [1:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	localparam int CW     = COORD_WIDTH;
	localparam int AW     = (CW > 24) ? CW : 24;
	localparam int SW     = (CW > 24) ? CW : 25;
	localparam int HW     = SW - 24 + CS_W;
	localparam int LW     = 25 + CS_W;
	localparam int TW     = SW + 36;
	localparam int VW     = TW - 30;
	localparam int SIDE_W = 3 * CW;

	localparam logic signed [VW-1:0] V_MAX = {{(VW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
	localparam logic signed [VW-1:0] V_MIN = ~V_MAX;
	localparam logic signed [30:0]   T_FAR = -31'sd536870912;

	logic en;

	// configuration register
	logic signed [ANGLE_W-1:0] twist_q;

	// input and squares
	logic                 v_s1, v_s2, v_s3;
	logic signed [CW-1:0] x_s1, y_s1, z_s1;
	logic signed [CW-1:0] x_s2, y_s2, z_s2;
	logic [AW-1:0]        ax, ay;
	logic [45:0]          sqx_s2, sqy_s2;
	logic                 far_s2, far_s3;
	logic [RAD_W-1:0]     rad_s3;
	logic [SIDE_W-1:0]    side_s3;

	// square root output
	logic              sq_v;
	logic [ROOT_W-1:0] sq_root;
	logic [SIDE_W:0]   sq_side;

	// smoothstep argument and polynomial
	logic signed [34:0] dif;
	logic signed [35:0] d2;
	logic signed [35:0] mag36;
	logic [31:0]        q0_7;
	logic [34:0]        r7;
	logic [31:0]        q7;

	logic        v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic [31:0] mag_s4, mag_s5;
	logic        neg_s4, neg_s5;
	logic        small_s4, small_s5, small_s6, small_s7, small_s8, small_s9, small_s10;
	logic        big_s4, big_s5;
	logic [63:0] prod7_s5;
	logic signed [30:0] t_s6, t_s7;
	logic signed [61:0] tt_s7;
	logic signed [33:0] t2, t2_s8;
	logic signed [64:0] t3p_s8;
	logic signed [64:0] t3_full;
	logic signed [39:0] poly;
	logic signed [39:0] poly_sh;
	logic signed [33:0] s_s9;
	logic signed [64:0] angp_s10;
	logic signed [64:0] angp_sh;
	logic [SIDE_W-1:0]  side_s4, side_s5, side_s6, side_s7, side_s8, side_s9, side_s10;

	// angle reduction and fold
	logic               v_s11, v_s12, v_s13, v_s14, v_s15, v_s16;
	logic signed [43:0] ang;
	logic signed [43:0] w_s11, w_s12, w_s13;
	logic signed [23:0] wh;
	logic signed [46:0] qp_s12;
	logic signed [14:0] q2p;
	logic signed [46:0] qm_s13;
	logic signed [46:0] rm_full;
	logic signed [33:0] rm_s14;
	logic signed [33:0] rc;
	logic signed [33:0] a0;
	logic signed [ANG_W-1:0] a0_s15, ang_s16;
	logic               flip_s16;
	logic [SIDE_W-1:0]  side_s11, side_s12, side_s13, side_s14, side_s15, side_s16;

	// CORDIC output
	logic                   cr_v;
	logic signed [CS_W-1:0] cr_cos, cr_sin;
	logic [SIDE_W-1:0]      cr_side;

	// dot products and saturation
	logic signed [CW-1:0]   cx_in, cy_in, cz_in;
	logic signed [SW-1:0]   xe, ye;
	logic signed [SW-25:0]  xh, yh;
	logic signed [24:0]     xl, yl;
	logic signed [CS_W-1:0] nsin;

	logic                 v_s17, v_s18, v_s19;
	logic signed [HW-1:0] hxc_s17, hys_s17, hyc_s17, hxn_s17;
	logic signed [LW-1:0] lxc_s17, lys_s17, lyc_s17, lxn_s17;
	logic signed [HW:0]   hi1_s18, hi2_s18;
	logic signed [LW:0]   lo1_s18, lo2_s18;
	logic signed [CW-1:0] z_s17, z_s18;
	logic signed [TW-1:0] tot1, tot2;
	logic signed [VW-1:0] v1, v2;
	logic signed [CW-1:0] mx_s19, my_s19, mz_s19;

	// output register and skid word
	logic                o_v_q, skid_v_q;
	logic [3*CW-1:0]     o_d_q, skid_d_q;

	assign en       = !skid_v_q;
	assign s_tready = en;

	// ---- configuration port ----
	assign pready = 1'b1;
	assign prdata = 32'(twist_q);

	// take a register write to address 0 in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			twist_q <= '0;
		end else if (psel && penable && pwrite && pready && (paddr == 2'd0)) begin
			twist_q <= pwdata[ANGLE_W-1:0];
		end
	end

	// ---- valid chain for the top-level stages ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0; v_s2  <= 1'b0; v_s3  <= 1'b0;
			v_s4  <= 1'b0; v_s5  <= 1'b0; v_s6  <= 1'b0;
			v_s7  <= 1'b0; v_s8  <= 1'b0; v_s9  <= 1'b0;
			v_s10 <= 1'b0; v_s11 <= 1'b0; v_s12 <= 1'b0;
			v_s13 <= 1'b0; v_s14 <= 1'b0; v_s15 <= 1'b0;
			v_s16 <= 1'b0; v_s17 <= 1'b0; v_s18 <= 1'b0;
			v_s19 <= 1'b0;
		end else if (en) begin
			v_s1  <= s_tvalid; v_s2  <= v_s1;  v_s3  <= v_s2;
			v_s4  <= sq_v;     v_s5  <= v_s4;  v_s6  <= v_s5;
			v_s7  <= v_s6;     v_s8  <= v_s7;  v_s9  <= v_s8;
			v_s10 <= v_s9;     v_s11 <= v_s10; v_s12 <= v_s11;
			v_s13 <= v_s12;    v_s14 <= v_s13; v_s15 <= v_s14;
			v_s16 <= v_s15;    v_s17 <= cr_v;  v_s18 <= v_s17;
			v_s19 <= v_s18;
		end
	end

	// ---- stages 1-3: capture, square, build the radicand ----
	assign ax = AW'(x_s1[CW-1] ? -x_s1 : x_s1);
	assign ay = AW'(y_s1[CW-1] ? -y_s1 : y_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= s_tdata[CW-1:0];
			y_s1 <= s_tdata[2*CW-1:CW];
			z_s1 <= s_tdata[3*CW-1:2*CW];

			sqx_s2 <= ax[22:0] * ax[22:0];
			sqy_s2 <= ay[22:0] * ay[22:0];
			far_s2 <= (ax >= AW'(NEAR_LIMIT)) || (ay >= AW'(NEAR_LIMIT));
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			z_s2   <= z_s1;

			rad_s3  <= RAD_W'({1'b0, sqx_s2} + {1'b0, sqy_s2}) << 16;
			far_s3  <= far_s2;
			side_s3 <= {z_s2, y_s2, x_s2};
		end
	end

	rtpr_sqrt #(
		.SIDE_W (SIDE_W + 1)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.radicand  (rad_s3),
		.side_in   ({far_s3, side_s3}),
		.out_valid (sq_v),
		.root      (sq_root),
		.side_out  (sq_side)
	);

	// ---- stages 4-6: t = (16 - r) / 14 in Q.26, truncated toward zero ----
	assign dif   = 35'sd268435456 - $signed({3'b000, sq_root});
	assign d2    = {dif, 1'b0};
	assign mag36 = d2[35] ? -d2 : d2;

	assign q0_7 = prod7_s5[63:32];
	assign r7   = {3'b000, mag_s5} - ({q0_7, 3'b000} - {3'b000, q0_7});
	assign q7   = q0_7 + 32'(r7 >= 35'd7);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s4   <= mag36[31:0];
			neg_s4   <= d2[35];
			small_s4 <= !sq_side[SIDE_W] && (sq_root < 32'd33554432);
			big_s4   <= sq_side[SIDE_W] || (sq_root >= 32'd2147483648);
			side_s4  <= sq_side[SIDE_W-1:0];

			prod7_s5 <= mag_s4 * 32'(RECIP_7);
			mag_s5   <= mag_s4;
			neg_s5   <= neg_s4;
			small_s5 <= small_s4;
			big_s5   <= big_s4;
			side_s5  <= side_s4;

			if (big_s5) begin
				t_s6 <= T_FAR;
			end else if (neg_s5) begin
				t_s6 <= -$signed(q7[30:0]);
			end else begin
				t_s6 <= $signed(q7[30:0]);
			end
			small_s6 <= small_s5;
			side_s6  <= side_s5;
		end
	end

	// ---- stages 7-10: smoothstep in Q.20, then scale by the register ----
	assign t2      = 34'(tt_s7 >>> 26);
	assign t3_full = t3p_s8 >>> 26;
	assign poly    = 40'sd3 * 40'(t2_s8) - 40'sd2 * 40'(t3_full);
	assign poly_sh = poly >>> 6;
	assign angp_sh = angp_s10 >>> 20;

	always_ff @(posedge clk) begin
		if (en) begin
			tt_s7    <= 62'(t_s6) * 62'(t_s6);
			t_s7     <= t_s6;
			small_s7 <= small_s6;
			side_s7  <= side_s6;

			t3p_s8   <= 65'(t2) * 65'(t_s7);
			t2_s8    <= t2;
			small_s8 <= small_s7;
			side_s8  <= side_s7;

			s_s9     <= poly_sh[33:0];
			small_s9 <= small_s8;
			side_s9  <= side_s8;

			angp_s10  <= 65'(s_s9) * 65'(twist_q);
			small_s10 <= small_s9;
			side_s10  <= side_s9;
		end
	end

	// ---- stages 11-16: wrap into [-pi, pi), then fold into [-pi/2, pi/2] ----
	assign ang     = small_s10 ? 44'(twist_q) : angp_sh[43:0];
	assign wh      = w_s11[43:20];
	assign q2p     = qp_s12[46:32];
	assign rm_full = 47'(w_s13) - qm_s13;
	assign rc      = rm_s14[33] ? rm_s14 + 34'(TWO_PI_Q28) :
	                 (rm_s14 >= 34'(TWO_PI_Q28)) ? rm_s14 - 34'(TWO_PI_Q28) : rm_s14;
	assign a0      = rc - 34'(PI_Q28);

	always_ff @(posedge clk) begin
		if (en) begin
			w_s11    <= ang + 44'(PI_Q28);
			side_s11 <= side_s10;

			qp_s12   <= 47'(wh) * 47'(RECIP_TWO_PI);
			w_s12    <= w_s11;
			side_s12 <= side_s11;

			qm_s13   <= 47'(q2p) * 47'(TWO_PI_Q28);
			w_s13    <= w_s12;
			side_s13 <= side_s12;

			rm_s14   <= rm_full[33:0];
			side_s14 <= side_s13;

			a0_s15   <= a0[ANG_W-1:0];
			side_s15 <= side_s14;

			if (a0_s15 > ANG_W'(HALF_PI_Q28)) begin
				ang_s16  <= a0_s15 - ANG_W'(PI_Q28);
				flip_s16 <= 1'b1;
			end else if (a0_s15 < -ANG_W'(HALF_PI_Q28)) begin
				ang_s16  <= a0_s15 + ANG_W'(PI_Q28);
				flip_s16 <= 1'b1;
			end else begin
				ang_s16  <= a0_s15;
				flip_s16 <= 1'b0;
			end
			side_s16 <= side_s15;
		end
	end

	rtpr_cordic #(
		.SIDE_W (SIDE_W)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s16),
		.angle     (ang_s16),
		.flip      (flip_s16),
		.side_in   (side_s16),
		.out_valid (cr_v),
		.cos_o     (cr_cos),
		.sin_o     (cr_sin),
		.side_out  (cr_side)
	);

	// ---- stages 17-19: rotate clockwise, round half up, saturate ----
	assign cx_in = cr_side[CW-1:0];
	assign cy_in = cr_side[2*CW-1:CW];
	assign cz_in = cr_side[3*CW-1:2*CW];
	assign xe    = SW'(cx_in);
	assign ye    = SW'(cy_in);
	assign xh    = xe[SW-1:24];
	assign yh    = ye[SW-1:24];
	assign xl    = {1'b0, xe[23:0]};
	assign yl    = {1'b0, ye[23:0]};
	assign nsin  = -cr_sin;

	assign tot1 = (TW'(hi1_s18) <<< 24) + TW'(lo1_s18);
	assign tot2 = (TW'(hi2_s18) <<< 24) + TW'(lo2_s18);
	assign v1   = VW'(tot1 >>> 30);
	assign v2   = VW'(tot2 >>> 30);

	always_ff @(posedge clk) begin
		if (en) begin
			hxc_s17 <= HW'(xh) * HW'(cr_cos);
			hys_s17 <= HW'(yh) * HW'(cr_sin);
			hyc_s17 <= HW'(yh) * HW'(cr_cos);
			hxn_s17 <= HW'(xh) * HW'(nsin);
			lxc_s17 <= LW'(xl) * LW'(cr_cos);
			lys_s17 <= LW'(yl) * LW'(cr_sin);
			lyc_s17 <= LW'(yl) * LW'(cr_cos);
			lxn_s17 <= LW'(xl) * LW'(nsin);
			z_s17   <= cz_in;

			hi1_s18 <= (HW+1)'(hxc_s17) + (HW+1)'(hys_s17);
			hi2_s18 <= (HW+1)'(hyc_s17) + (HW+1)'(hxn_s17);
			lo1_s18 <= (LW+1)'(lxc_s17) + (LW+1)'(lys_s17) + (LW+1)'(536870912);
			lo2_s18 <= (LW+1)'(lyc_s17) + (LW+1)'(lxn_s17) + (LW+1)'(536870912);
			z_s18   <= z_s17;

			mx_s19 <= (v1 > V_MAX) ? V_MAX[CW-1:0] : (v1 < V_MIN) ? V_MIN[CW-1:0] : v1[CW-1:0];
			my_s19 <= (v2 > V_MAX) ? V_MAX[CW-1:0] : (v2 < V_MIN) ? V_MIN[CW-1:0] : v2[CW-1:0];
			mz_s19 <= z_s18;
		end
	end

	// ---- output register with skid word ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q    <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (m_tready || !o_v_q) begin
			if (skid_v_q) begin
				o_v_q    <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				o_v_q <= v_s19;
			end
		end else if (v_s19 && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_tready || !o_v_q) begin
			o_d_q <= skid_v_q ? skid_d_q : {mz_s19, my_s19, mx_s19};
		end else if (!skid_v_q) begin
			skid_d_q <= {mz_s19, my_s19, mx_s19};
		end
	end

	assign m_tvalid = o_v_q;
	assign m_tdata  = TDW'(o_d_q);

endmodule

// ----- sv/rtpr_check.sv -----
// ----------------------------------------------------------------------------
// rtpr_check
// Port-level checks for the radial twist point rotation block, bound to
// the top level.
// ----------------------------------------------------------------------------
module rtpr_check import rtpr_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	localparam int TDW = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
	input logic           clk,
	input logic           arst_n,
	input logic [TDW-1:0] s_tdata,
	input logic           s_tvalid,
	input logic           s_tready,
	input logic [TDW-1:0] m_tdata,
	input logic           m_tvalid,
	input logic           m_tready,
	input logic           psel,
	input logic           penable,
	input logic           pwrite,
	input logic [1:0]     paddr,
	input logic [31:0]    pwdata,
	input logic [31:0]    prdata,
	input logic           pready
);

	// hold a stalled output word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output word changed while stalled");

	// a completed write shows on the read data next cycle
	a_reg_write: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr == 2'd0
		|=> prdata[30:0] == $past(pwdata[30:0]))
		else $error("twist register did not take the write");

	// a stall leaves the input refusing words only while the output waits
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no output word waiting");

endmodule

bind radial_twist_point_rotation rtpr_check #(
	.COORD_WIDTH (COORD_WIDTH)
) u_rtpr_check (.*);
